FILE: sv/mat_pkg.sv
// Shared types, character codes and queue sizing for the markup-to-ANSI translator.
package mat_pkg;

  // Input item and result item as they appear on the ports.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } out_item_t;

  // Output plan for one input byte, emitted in field order by the back end.
  typedef struct packed {
    logic       indent;      // seven spaces
    logic [1:0] tag_cnt;     // leading bytes of ".SH" to replay
    logic       head_open;   // newline, then bold on
    logic [1:0] lit_cnt;     // "/" or "/f" released before the byte
    logic       esc_en;      // one style escape
    logic [7:0] esc_code;    // its digit character
    logic       byte_en;     // one plain byte
    logic [7:0] byte_val;
    logic       head_close;  // style reset, then newline
    logic [1:0] tail_cnt;    // "/" or "/f" flushed at end of file
  } cmd_t;

  // Command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UH    = 8'h48;
  localparam logic [7:0] CH_UI    = 8'h49;
  localparam logic [7:0] CH_UP    = 8'h50;
  localparam logic [7:0] CH_US    = 8'h53;
  localparam logic [7:0] CH_UU    = 8'h55;
  localparam logic [7:0] CH_LB    = 8'h5B;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LM    = 8'h6D;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Bytes of the heading tag ".SH ".
  function automatic logic [7:0] sh_tag(input logic [1:0] k);
    logic [7:0] c;
    unique case (k)
      2'd0:    c = CH_DOT;
      2'd1:    c = CH_US;
      2'd2:    c = CH_UH;
      default: c = CH_SP;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/markup_to_ansi_translator.sv
// Top level of the markup-to-ANSI translator: front end, command queue, back end.
// Plans pass the command queue and the back end's plan register to the output register.
// Throughput: one result byte per cycle while results are popped, set by the back end's
//   byte sequencer; an input byte that yields at most one result transfers every cycle
//   while the queue has room, longer expansions (up to eleven bytes) are sent byte by byte.
// Reset (rst, synchronous): clears line state, the command queue and out_valid.
module markup_to_ansi_translator
  import mat_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  // Front to queue: one plan per input byte that yields output.
  logic q_wr;
  cmd_t q_wr_cmd;
  logic q_full;

  // Queue to back end.
  logic q_rd;
  cmd_t q_rd_cmd;
  logic q_nonempty;

  // Input side stalls only when the command queue has no free slot.
  assign full = q_full;

  // Classify each byte and update line state as it transfers.
  mat_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_cmd  (q_wr_cmd)
  );

  // Hold plans so either side may stall on its own.
  mat_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr),
    .wr_cmd   (q_wr_cmd),
    .full     (q_full),
    .rd_en    (q_rd),
    .rd_cmd   (q_rd_cmd),
    .nonempty (q_nonempty)
  );

  // Expand plans into bytes and drive the result queue interface.
  mat_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_nonempty),
    .q_cmd   (q_rd_cmd),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

FILE: sv/mat_front.sv
// Front end: tracks line state, classifies each input byte into an output plan.
module mat_front
  import mat_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t item,
  input  logic     q_full,
  output logic     q_wr,
  output cmd_t     q_cmd
);

  typedef enum logic [5:0] {
    M_START      = 6'b000001,
    M_PREFIX     = 6'b000010,
    M_COMMENT    = 6'b000100,
    M_HEAD_EMPTY = 6'b001000,
    M_HEAD_HELD  = 6'b010000,
    M_BODY       = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [1:0] lit_cnt;
    logic       esc_en;
    logic [7:0] esc_code;
    logic       byte_en;
    logic [7:0] byte_val;
    logic [1:0] esc_next;
    logic       line_end;
  } body_t;

  mode_t      mode, mode_next;
  logic [1:0] pmatch, pmatch_next;
  logic [1:0] escp, escp_next;
  logic [7:0] held, held_next;
  logic [7:0] b;
  logic       take;
  logic       body_on;
  logic [1:0] body_esc;
  body_t      br;
  cmd_t       cmd;

  function automatic body_t plain_step(input body_t r_in, input logic [7:0] c);
    body_t r;
    r = r_in;
    if (c == CH_SLASH) begin
      r.esc_next = 2'd1;
    end else begin
      r.byte_en  = 1'b1;
      r.byte_val = c;
      r.line_end = (c == CH_NL);
    end
    return r;
  endfunction

  function automatic body_t body_step(input logic [1:0] e, input logic [7:0] c);
    body_t r;
    r = '0;
    unique case (e)
      2'd1: begin
        if (c == CH_SLASH) begin
          r.lit_cnt = 2'd1;
        end else if (c == CH_LF) begin
          r.esc_next = 2'd2;
        end else begin
          r.lit_cnt = 2'd1;
          r = plain_step(r, c);
        end
      end
      2'd2: begin
        if (c == CH_UB || c == CH_UI || c == CH_UU || c == CH_UP) begin
          r.esc_en = 1'b1;
          unique case (c)
            CH_UB:   r.esc_code = CH_1;
            CH_UI:   r.esc_code = CH_3;
            CH_UU:   r.esc_code = CH_4;
            default: r.esc_code = CH_0;
          endcase
        end else begin
          r.lit_cnt = 2'd2;
          r = plain_step(r, c);
        end
      end
      default: r = plain_step(r, c);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] upper(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) ? c - CASE_GAP : c;
  endfunction

  assign b    = item.text_byte;
  assign take = push && !q_full;

  always_comb begin
    mode_next   = mode;
    pmatch_next = pmatch;
    escp_next   = escp;
    held_next   = held;
    cmd         = '0;
    body_on     = 1'b0;
    body_esc    = escp;

    unique case (mode)
      M_COMMENT: begin
        if (b == CH_NL) mode_next = M_START;
      end
      M_PREFIX: begin
        if (b == sh_tag(pmatch)) begin
          if (pmatch == 2'd3) begin
            pmatch_next   = '0;
            cmd.head_open = 1'b1;
            mode_next     = M_HEAD_EMPTY;
          end else begin
            pmatch_next = pmatch + 2'd1;
          end
        end else begin
          // Tag broken: replay what matched as an ordinary line.
          pmatch_next = '0;
          cmd.indent  = 1'b1;
          cmd.tag_cnt = pmatch;
          mode_next   = M_BODY;
          body_on     = 1'b1;
          body_esc    = 2'd0;
        end
      end
      M_HEAD_EMPTY: begin
        if (b == CH_NL) begin
          cmd.head_close = 1'b1;
          mode_next      = M_START;
        end else begin
          held_next = b;
          mode_next = M_HEAD_HELD;
        end
      end
      M_HEAD_HELD: begin
        // Release the held byte; the newline itself is the dropped last byte.
        cmd.byte_en  = 1'b1;
        cmd.byte_val = upper(held);
        if (b == CH_NL) begin
          held_next      = '0;
          cmd.head_close = 1'b1;
          mode_next      = M_START;
        end else begin
          held_next = b;
        end
      end
      M_BODY: begin
        body_on = 1'b1;
      end
      default: begin
        pmatch_next = '0;
        escp_next   = '0;
        if (b == CH_HASH) begin
          mode_next = M_COMMENT;
        end else if (b == CH_DOT) begin
          mode_next   = M_PREFIX;
          pmatch_next = 2'd1;
        end else begin
          cmd.indent = 1'b1;
          mode_next  = M_BODY;
          body_on    = 1'b1;
          body_esc   = 2'd0;
        end
      end
    endcase

    br = body_step(body_esc, b);
    if (body_on) begin
      cmd.lit_cnt  = br.lit_cnt;
      cmd.esc_en   = br.esc_en;
      cmd.esc_code = br.esc_code;
      cmd.byte_en  = br.byte_en;
      cmd.byte_val = br.byte_val;
      escp_next    = br.esc_next;
      if (br.line_end) mode_next = M_START;
    end

    // End of file: flush whatever is pending, then return to reset state.
    if (item.final_byte) begin
      if (mode_next == M_PREFIX) begin
        cmd.indent  = 1'b1;
        cmd.tag_cnt = pmatch_next;
      end else if (mode_next == M_HEAD_EMPTY || mode_next == M_HEAD_HELD) begin
        cmd.head_close = 1'b1;
      end else if (mode_next == M_BODY) begin
        cmd.tail_cnt = (escp_next == 2'd3) ? 2'd0 : escp_next;
      end
      mode_next   = M_START;
      pmatch_next = '0;
      escp_next   = '0;
      held_next   = '0;
    end
  end

  assign q_cmd = cmd;
  assign q_wr  = take && (cmd.indent || (cmd.tag_cnt != 2'd0) || cmd.head_open ||
                          (cmd.lit_cnt != 2'd0) || cmd.esc_en || cmd.byte_en ||
                          cmd.head_close || (cmd.tail_cnt != 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_START;
      pmatch <= '0;
      escp   <= '0;
    end else if (take) begin
      mode   <= mode_next;
      pmatch <= pmatch_next;
      escp   <= escp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) held <= held_next;
  end

endmodule

FILE: sv/mat_cmd_fifo.sv
// Short command queue that decouples the front end from the back end.
module mat_cmd_fifo
  import mat_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic nonempty
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign rd_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_cmd;
  end

endmodule

FILE: sv/mat_back.sv
// Back end: expands plans into output register bytes, one per cycle unless a byte waits.
module mat_back
  import mat_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_rd,
  input  logic      pop,
  output logic      empty,
  output out_item_t result
);

  localparam int SEG_INDENT = 0;
  localparam int SEG_TAG    = 1;
  localparam int SEG_OPEN   = 2;
  localparam int SEG_LIT    = 3;
  localparam int SEG_ESC    = 4;
  localparam int SEG_BYTE   = 5;
  localparam int SEG_CLOSE  = 6;
  localparam int SEG_TAIL   = 7;

  localparam logic [2:0] INDENT_LEN = 3'd7;
  localparam logic [2:0] OPEN_LEN   = 3'd5;
  localparam logic [2:0] ESC_LEN    = 3'd4;
  localparam logic [2:0] CLOSE_LEN  = 3'd5;

  cmd_t      cur;
  logic [7:0] mask, mask_after, seg;
  logic [2:0] cnt, seg_len;
  logic [7:0] seg_byte;
  logic       last_in_seg, out_free, emit, out_valid;
  out_item_t  out_reg;

  function automatic logic [7:0] seg_mask(input cmd_t c);
    logic [7:0] m;
    m[SEG_INDENT] = c.indent;
    m[SEG_TAG]    = (c.tag_cnt != 2'd0);
    m[SEG_OPEN]   = c.head_open;
    m[SEG_LIT]    = (c.lit_cnt != 2'd0);
    m[SEG_ESC]    = c.esc_en;
    m[SEG_BYTE]   = c.byte_en;
    m[SEG_CLOSE]  = c.head_close;
    m[SEG_TAIL]   = (c.tail_cnt != 2'd0);
    return m;
  endfunction

  // Lowest pending segment is the one being emitted.
  assign seg = mask & (~mask + 8'd1);

  always_comb begin
    seg_len  = '0;
    seg_byte = '0;
    if (seg[SEG_INDENT]) begin
      seg_len  = INDENT_LEN;
      seg_byte = CH_SP;
    end else if (seg[SEG_TAG]) begin
      seg_len  = {1'b0, cur.tag_cnt};
      seg_byte = sh_tag(cnt[1:0]);
    end else if (seg[SEG_OPEN]) begin
      seg_len = OPEN_LEN;
      unique case (cnt)
        3'd0:    seg_byte = CH_NL;
        3'd1:    seg_byte = CH_ESC;
        3'd2:    seg_byte = CH_LB;
        3'd3:    seg_byte = CH_1;
        default: seg_byte = CH_LM;
      endcase
    end else if (seg[SEG_LIT]) begin
      seg_len  = {1'b0, cur.lit_cnt};
      seg_byte = cnt[0] ? CH_LF : CH_SLASH;
    end else if (seg[SEG_ESC]) begin
      seg_len = ESC_LEN;
      unique case (cnt)
        3'd0:    seg_byte = CH_ESC;
        3'd1:    seg_byte = CH_LB;
        3'd2:    seg_byte = cur.esc_code;
        default: seg_byte = CH_LM;
      endcase
    end else if (seg[SEG_BYTE]) begin
      seg_len  = 3'd1;
      seg_byte = cur.byte_val;
    end else if (seg[SEG_CLOSE]) begin
      seg_len = CLOSE_LEN;
      unique case (cnt)
        3'd0:    seg_byte = CH_ESC;
        3'd1:    seg_byte = CH_LB;
        3'd2:    seg_byte = CH_0;
        3'd3:    seg_byte = CH_LM;
        default: seg_byte = CH_NL;
      endcase
    end else if (seg[SEG_TAIL]) begin
      seg_len  = {1'b0, cur.tail_cnt};
      seg_byte = cnt[0] ? CH_LF : CH_SLASH;
    end
  end

  assign last_in_seg = (cnt == seg_len - 3'd1);
  assign mask_after  = last_in_seg ? (mask & ~seg) : mask;
  assign out_free    = !out_valid || pop;
  assign emit        = (mask != '0) && out_free;
  // Load the next plan when idle, or as the current plan sends its last byte.
  assign q_rd        = q_valid && ((mask == '0) || (emit && (mask_after == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      mask      <= '0;
      cnt       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_rd) begin
        mask <= seg_mask(q_cmd);
        cnt  <= '0;
      end else if (emit) begin
        mask <= mask_after;
        cnt  <= last_in_seg ? 3'd0 : cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_reg.out_byte <= seg_byte;
      out_reg.run_end  <= (mask_after == '0);
    end
    if (q_rd) cur <= q_cmd;
  end

  assign empty  = !out_valid;
  assign result = out_reg;

endmodule

FILE: sv/mat_checker.sv
// Port-level checks for the markup-to-ANSI translator, bound to the top level.
module mat_checker
  import mat_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  // Reset leaves no result waiting and room for input.
  a_reset_clean: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result or full seen right after reset");

  // A waiting result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // Bytes of one run follow each other without a gap.
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.run_end) |=> !empty)
    else $error("gap inside a result run");

endmodule

bind markup_to_ansi_translator mat_checker u_mat_checker (.*);
